/* rtl/kab_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kab_pkg
// shared widths, command codes and jump table entry type for the
// k-th ancestor block
// ----------------------------------------------------------------------------
package kab_pkg;

    localparam int CMD_W   = 2;
    localparam int NODE_W  = 10;
    localparam int STEPS_W = 20;
    localparam int CNT_W   = 11;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_LEVELS    = 10;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef struct packed {
        logic              none;
        logic [NODE_W-1:0] node;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry ENTRY_NONE = '{none: 1'b1, node: '0};

endpackage : kab_pkg
`default_nettype wire

/* rtl/kab_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kab_in_if
// command channel: valid/ready handshake with command payload
// ----------------------------------------------------------------------------
interface kab_in_if import kab_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  parent_node;
    logic [STEPS_W-1:0] steps;

    modport source (output valid, cmd, node, parent_node, steps, input ready);
    modport sink   (input valid, cmd, node, parent_node, steps, output ready);

endinterface : kab_in_if
`default_nettype wire

/* rtl/kab_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kab_out_if
// result channel: valid/ready handshake with query answer payload
// ----------------------------------------------------------------------------
interface kab_out_if import kab_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              found;
    logic [NODE_W-1:0] ancestor;

    modport source (output valid, found, ancestor, input ready);
    modport sink   (input valid, found, ancestor, output ready);

endinterface : kab_out_if
`default_nettype wire

/* rtl/kab_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kab_ram
// generic simple dual-port ram, one write port, one read port with
// registered read data
// ----------------------------------------------------------------------------
module kab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : kab_ram
`default_nettype wire

/* rtl/kth_ancestor_binary_lifting.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting
// k-th ancestor queries on a rooted tree through a binary lifting jump table
// ----------------------------------------------------------------------------
// The jump table sits in one ram, entry (node u, level i) at address
// i * min(MAX_NODES, 1024) + u, each a node number with a none mark; it holds
// no reset value and must be loaded and built before it is queried. A build
// fills the levels above zero for the n nodes in use: every entry is one
// dependent pair of reads through the ram's registered read port, written
// from the second read when the link is usable and as none when it is not.
// In a query each set bit of k is one table read that depends on the last.
// One command is worked on at a time. A finished answer waits in the output
// register, and loads and builds are still taken while it waits; a query that
// ends while an earlier answer still waits holds until that answer is taken.
// ----------------------------------------------------------------------------
module kth_ancestor_binary_lifting import kab_pkg::*; #(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int LEVELS    = DEF_LEVELS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    kab_in_if.sink                i_in,
    kab_out_if.source             o_out
);

    localparam int NODES_EFF = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
    localparam int U_W       = $clog2(NODES_EFF);
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DEPTH     = NODES_EFF * LEVELS;
    localparam int ADDR_W    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_BRD,
        S_BLINK,
        S_BWR,
        S_QSTEP,
        S_QWAIT,
        S_QDONE
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_node_count;
    logic [LVL_W-1:0]    r_lvl;
    logic [U_W-1:0]      r_u;
    logic [U_W-1:0]      r_cur;
    logic [LEVELS-1:0]   r_k;
    logic                r_ok;
    logic                r_out_valid;
    logic                r_out_found;
    logic [NODE_W-1:0]   r_out_ancestor;

    logic [CNT_W-1:0]    w_cnt;
    logic                w_accept;
    logic                w_out_take;
    logic                w_start_ok;
    logic                w_link_ok;
    logic                w_last_u;
    logic                w_last_lvl;
    t_entry              w_rd;
    logic [ENTRY_W-1:0]  w_rdata;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    t_entry              ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [U_W-1:0]   u);
        return ADDR_W'(lvl) * ADDR_W'(NODES_EFF) + ADDR_W'(u);
    endfunction

    assign w_cnt      = (r_node_count > CNT_W'(NODES_EFF)) ? CNT_W'(NODES_EFF)
                                                          : r_node_count;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_take = r_out_valid && o_out.ready;
    assign w_start_ok = (CNT_W'(i_in.node) < w_cnt) &&
                        ((i_in.steps >> LEVELS) == '0);
    assign w_rd       = t_entry'(w_rdata);
    assign w_link_ok  = !w_rd.none && (CNT_W'(w_rd.node) < w_cnt);
    assign w_last_u   = (CNT_W'(r_u) + CNT_W'(1)) == w_cnt;
    assign w_last_lvl = r_lvl == LVL_W'(LEVELS - 1);

    assign i_in.ready     = r_state == S_IDLE;
    assign o_out.valid    = r_out_valid;
    assign o_out.found    = r_out_found;
    assign o_out.ancestor = r_out_ancestor;

    // table port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = f_addr(r_lvl, r_u);
        ram_wdata = ENTRY_NONE;
        ram_raddr = f_addr(LVL_W'(r_lvl - LVL_W'(1)), r_u);
        unique case (r_state)
            S_IDLE: begin
                ram_waddr = f_addr('0, U_W'(i_in.node));
                ram_wdata = (32'(i_in.parent_node) < MAX_NODES)
                          ? t_entry'({1'b0, i_in.parent_node}) : ENTRY_NONE;
                ram_we    = w_accept && (i_in.cmd == CMD_LOAD) &&
                            (32'(i_in.node) < MAX_NODES);
            end
            S_ROOT: begin
                ram_waddr = f_addr('0, '0);
                ram_we    = 1'b1;
            end
            S_BLINK: begin
                ram_raddr = f_addr(LVL_W'(r_lvl - LVL_W'(1)), U_W'(w_rd.node));
                ram_we    = !w_link_ok;
            end
            S_BWR: begin
                ram_wdata = w_rd;
                ram_we    = 1'b1;
            end
            S_QSTEP, S_QWAIT: begin
                ram_raddr = f_addr(r_lvl, r_cur);
            end
            default: begin
            end
        endcase
    end

    kab_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= CNT_RESET;
            r_out_valid  <= 1'b0;
            r_lvl        <= '0;
            r_u          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            // in S_QDONE a taken answer is always replaced by the new one
            if (w_out_take && (r_state != S_QDONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_in.cmd)
                            CMD_BUILD: begin
                                if (w_cnt != '0) begin
                                    r_state <= S_ROOT;
                                end
                            end
                            CMD_QUERY: begin
                                r_cur <= U_W'(i_in.node);
                                r_k   <= i_in.steps[LEVELS-1:0];
                                r_lvl <= '0;
                                r_ok  <= w_start_ok;
                                r_state <= w_start_ok ? S_QSTEP : S_QDONE;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ROOT: begin
                    r_u   <= '0;
                    r_lvl <= LVL_W'(1);
                    r_state <= (LEVELS > 1) ? S_BRD : S_IDLE;
                end
                S_BRD: begin
                    r_state <= S_BLINK;
                end
                S_BLINK, S_BWR: begin
                    if ((r_state == S_BLINK) && w_link_ok) begin
                        r_state <= S_BWR;
                    end else if (w_last_u) begin
                        r_u <= '0;
                        if (w_last_lvl) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_lvl   <= r_lvl + LVL_W'(1);
                            r_state <= S_BRD;
                        end
                    end else begin
                        r_u     <= r_u + U_W'(1);
                        r_state <= S_BRD;
                    end
                end
                S_QSTEP: begin
                    priority if (r_k == '0) begin
                        r_state <= S_QDONE;
                    end else if (r_k[0]) begin
                        r_state <= S_QWAIT;
                    end else begin
                        r_k   <= r_k >> 1;
                        r_lvl <= r_lvl + LVL_W'(1);
                    end
                end
                S_QWAIT: begin
                    if (w_link_ok) begin
                        r_cur   <= U_W'(w_rd.node);
                        r_k     <= r_k >> 1;
                        r_lvl   <= r_lvl + LVL_W'(1);
                        r_state <= S_QSTEP;
                    end else begin
                        r_ok    <= 1'b0;
                        r_state <= S_QDONE;
                    end
                end
                S_QDONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_found    <= r_ok;
                        r_out_ancestor <= r_ok ? NODE_W'(r_cur) : '0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // answer without an ancestor carries node zero
    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.found |-> o_out.ancestor == '0)
        else $error("result without ancestor has nonzero node");

    // finished query lands in the output register
    a_done_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QDONE) && (!r_out_valid || o_out.ready) |=> r_out_valid)
        else $error("finished query not posted");

    // the walk never stands on a node outside the tree in use
    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QSTEP) || (r_state == S_QWAIT) |-> CNT_W'(r_cur) < w_cnt)
        else $error("query walk left the nodes in use");

    // build writes only the levels above zero, save for the root entry
    a_build_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && ((r_state == S_BLINK) || (r_state == S_BWR)) |-> r_lvl != '0)
        else $error("build overwrote a parent entry");
`endif

endmodule : kth_ancestor_binary_lifting
`default_nettype wire

/* tb/tb_kth_ancestor_binary_lifting.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kth_ancestor_binary_lifting
// self-checking bench for the k-th ancestor block
// ----------------------------------------------------------------------------
// Plants random trees through load commands, builds the jump table and fires
// ancestor queries. A scoreboard class keeps its own jump table and node
// count, predicts each answer and checks every result transfer in order.
// Runs several node counts, from empty to over-range, under a mix of
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_kth_ancestor_binary_lifting;
    import kab_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned      LIMIT      = 1500000;
    localparam int unsigned      SMALL_TREE = 128;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] ancestor;
    } t_answer;

    class ancestor_tracker;
        t_entry           jump [0:DEF_MAX_NODES*DEF_LEVELS-1];
        logic [CNT_W-1:0] node_count;
        t_answer          pending_answers[$];
        int               errors;

        function new();
            node_count = CNT_RESET;
            errors     = 0;
            foreach (jump[i]) jump[i] = '0;
        endfunction

        function void set_node_count(logic [CNT_W-1:0] value);
            node_count = value;
        endfunction

        function int unsigned nodes_in_use();
            return (node_count > DEF_MAX_NODES) ? DEF_MAX_NODES : node_count;
        endfunction

        function bit usable(t_entry e, int unsigned n);
            return !e.none && (e.node < n);
        endfunction

        function void build_levels();
            int unsigned n;
            t_entry      prev;
            n = nodes_in_use();
            if (n == 0) return;
            for (int lv = 0; lv < DEF_LEVELS; lv++) jump[lv] = ENTRY_NONE;
            for (int lv = 1; lv < DEF_LEVELS; lv++) begin
                for (int unsigned u = 0; u < n; u++) begin
                    prev = jump[u*DEF_LEVELS + lv - 1];
                    if (usable(prev, n)) begin
                        jump[u*DEF_LEVELS + lv] = jump[prev.node*DEF_LEVELS + lv - 1];
                    end else begin
                        jump[u*DEF_LEVELS + lv] = ENTRY_NONE;
                    end
                end
            end
        endfunction

        function t_answer climb(logic [NODE_W-1:0] start, logic [STEPS_W-1:0] steps);
            int unsigned       n;
            logic [NODE_W-1:0] cur;
            bit                ok;
            t_entry            e;
            t_answer           ans;
            n   = nodes_in_use();
            cur = start;
            ok  = (start < n) && ((steps >> DEF_LEVELS) == 0);
            for (int lv = 0; lv < DEF_LEVELS; lv++) begin
                if (ok && steps[lv]) begin
                    e = jump[cur*DEF_LEVELS + lv];
                    if (usable(e, n)) cur = e.node;
                    else ok = 1'b0;
                end
            end
            ans.found    = ok;
            ans.ancestor = ok ? cur : '0;
            return ans;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] node,
                                   logic [NODE_W-1:0] parent, logic [STEPS_W-1:0] steps);
            case (cmd)
                CMD_LOAD: begin
                    jump[node*DEF_LEVELS] = '{none: 1'b0, node: parent};
                end
                CMD_BUILD: begin
                    build_levels();
                end
                CMD_QUERY: begin
                    pending_answers.push_back(climb(node, steps));
                end
                default: begin
                end
            endcase
        endfunction

        function void check_answer(logic found, logic [NODE_W-1:0] ancestor);
            t_answer exp;
            if (pending_answers.size() == 0) begin
                $error("unexpected result: found %0b ancestor %0d", found, ancestor);
                errors++;
                return;
            end
            exp = pending_answers.pop_front();
            if (found !== exp.found) begin
                $error("found: expected %0b actual %0b", exp.found, found);
                errors++;
            end
            if (ancestor !== exp.ancestor) begin
                $error("ancestor: expected %0d actual %0d", exp.ancestor, ancestor);
                errors++;
            end
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    kab_in_if  in_ch ();
    kab_out_if out_ch ();

    kth_ancestor_binary_lifting #(
        .MAX_NODES (DEF_MAX_NODES),
        .LEVELS    (DEF_LEVELS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    ancestor_tracker sb;
    int              idle_mode;
    int unsigned     max_ready;
    int unsigned     cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit sender_gap();
        case (idle_mode)
            1:       return $urandom_range(0, 99) < 71;
            3:       return $urandom_range(0, 99) < 24;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            2:       return $urandom_range(0, 99) < 71;
            3:       return $urandom_range(0, 99) < 24;
            default: return 1'b0;
        endcase
    endfunction

    task automatic push_command(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] node,
                                input logic [NODE_W-1:0] parent,
                                input logic [STEPS_W-1:0] steps);
        @(negedge i_clk);
        while (sender_gap()) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.cmd         = cmd;
        in_ch.node        = node;
        in_ch.parent_node = parent;
        in_ch.steps       = steps;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_command(cmd, node, parent, steps);
    endtask

    // drop valid, then let the block finish whatever it holds
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2*DEF_LEVELS + 10) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [CNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        sb.set_node_count(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic plant_tree(input int unsigned n);
        int unsigned       chain;
        logic [NODE_W-1:0] par;
        chain = $urandom_range(0, 1) ? 90 : 30;
        for (int unsigned u = 0; u < n; u++) begin
            if (u == 0) par = NODE_W'($urandom);
            else if ($urandom_range(0, 99) < chain) par = NODE_W'(u - 1);
            else if ($urandom_range(0, 99) < 95) par = NODE_W'($urandom_range(0, u - 1));
            else par = NODE_W'($urandom);
            push_command(CMD_LOAD, NODE_W'(u), par, STEPS_W'($urandom));
        end
        push_command(CMD_BUILD, NODE_W'($urandom), NODE_W'($urandom), STEPS_W'($urandom));
        if (n > max_ready) max_ready = n;
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] count, input int unsigned quota);
        int unsigned       n;
        int unsigned       done;
        int unsigned       r;
        int unsigned       roll;
        logic [NODE_W-1:0] nd;
        logic [NODE_W-1:0] par;
        logic [STEPS_W-1:0] k;
        wait_idle();
        write_node_count(count);
        n = (count > DEF_MAX_NODES) ? DEF_MAX_NODES : count;
        if (n > 0 && (n <= SMALL_TREE || n > max_ready)) plant_tree(n);
        done = 0;
        while (done < quota) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                if (n > 0 && $urandom_range(0, 99) < 85) nd = NODE_W'($urandom_range(0, n - 1));
                else nd = NODE_W'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 50) k = STEPS_W'($urandom_range(0, (n < 1023) ? n : 1023));
                else if (roll < 80) k = STEPS_W'($urandom_range(0, 1023));
                else if (roll < 90) k = STEPS_W'(1) << $urandom_range(0, DEF_LEVELS - 1);
                else k = STEPS_W'($urandom) | (STEPS_W'(1) << $urandom_range(DEF_LEVELS, 19));
                push_command(CMD_QUERY, nd, NODE_W'($urandom), k);
                done++;
            end else if (r < 85) begin
                if (n > 0 && $urandom_range(0, 99) < 60) nd = NODE_W'($urandom_range(0, n - 1));
                else nd = NODE_W'($urandom);
                if (nd > 0 && $urandom_range(0, 99) < 70) par = NODE_W'($urandom_range(0, nd - 1));
                else par = NODE_W'($urandom);
                push_command(CMD_LOAD, nd, par, STEPS_W'($urandom));
                done++;
            end else if (r < 90 && n <= SMALL_TREE) begin
                push_command(CMD_BUILD, NODE_W'($urandom), NODE_W'($urandom),
                             STEPS_W'($urandom));
                done++;
            end else begin
                push_command(CMD_UNUSED, NODE_W'($urandom), NODE_W'($urandom),
                             STEPS_W'($urandom));
            end
        end
        // closing query so the block is known idle once it answers
        push_command(CMD_QUERY, (n > 0) ? NODE_W'($urandom_range(0, n - 1)) : '0, '0, '0);
    endtask

    // receive side: ready set at the falling edge, result transfer at the rising edge
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            out_ch.ready = !receiver_stall();
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready)
                sb.check_answer(out_ch.found, out_ch.ancestor);
        end
    end

    initial begin
        logic [CNT_W-1:0] counts [10];
        sb                = new();
        idle_mode         = 0;
        max_ready         = 0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = '0;
        in_ch.node        = '0;
        in_ch.parent_node = '0;
        in_ch.steps       = '0;
        out_ch.ready      = 1'b0;
        counts = '{11'd0, 11'd2, 11'd1, 11'd7, 11'd1024, 11'd2047, 11'd37, 11'd128,
                   11'd3, 11'd64};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // single root at reset count
        push_command(CMD_LOAD, '0, 10'd1023, '0);
        push_command(CMD_BUILD, '0, '0, '0);
        push_command(CMD_QUERY, '0, '0, '0);
        push_command(CMD_QUERY, '0, '0, 20'd1);
        push_command(CMD_QUERY, 10'd1023, 10'd1023, '0);
        push_command(CMD_QUERY, '0, '0, 20'hFFFFF);
        push_command(CMD_UNUSED, 10'd1023, 10'd1023, 20'hFFFFF);
        push_command(CMD_QUERY, '0, '0, '0);
        if (max_ready < 1) max_ready = 1;

        // short chain 3 -> 2 -> 1 -> 0
        wait_idle();
        write_node_count(11'd4);
        push_command(CMD_LOAD, 10'd0, 10'd0, '0);
        push_command(CMD_LOAD, 10'd1, 10'd0, '0);
        push_command(CMD_LOAD, 10'd2, 10'd1, '0);
        push_command(CMD_LOAD, 10'd3, 10'd2, '0);
        push_command(CMD_BUILD, '0, '0, '0);
        push_command(CMD_QUERY, 10'd3, '0, 20'd3);
        push_command(CMD_QUERY, 10'd3, '0, 20'd2);
        push_command(CMD_QUERY, 10'd3, '0, 20'd4);
        push_command(CMD_QUERY, 10'd2, '0, 20'd1024);
        push_command(CMD_QUERY, 10'd2, '0, 20'd0);
        // link out of range
        push_command(CMD_LOAD, 10'd3, 10'd1000, '0);
        push_command(CMD_BUILD, '0, '0, '0);
        push_command(CMD_QUERY, 10'd3, '0, 20'd1);
        push_command(CMD_QUERY, 10'd2, '0, 20'd1);
        push_command(CMD_QUERY, 10'd1023, '0, 20'd1);
        max_ready = 4;

        for (int p = 0; p < 13; p++) begin
            idle_mode = p % 4;
            if (p < 10) run_phase(counts[p], 16);
            else run_phase(CNT_W'($urandom_range(1, 64)), 16);
        end

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule : tb_kth_ancestor_binary_lifting

/* sim.f */
rtl/kab_pkg.sv
rtl/kab_in_if.sv
rtl/kab_out_if.sv
rtl/kab_ram.sv
rtl/kth_ancestor_binary_lifting.sv
tb/tb_kth_ancestor_binary_lifting.sv
